// File: sv/cba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_pkg
// Shared constants and types for the circular bitstring analyzer.
// ----------------------------------------------------------------------------
package cba_pkg;

	localparam int MAX_BITS_DEF = 16;
	localparam int IN_W         = 16;
	localparam int LEN_W        = 5;
	localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;
	localparam int QUEUE_DEPTH  = 2;

	typedef struct packed {
		logic [IN_W-1:0]  min_rotation;
		logic [LEN_W-1:0] period;
		logic [IN_W-1:0]  link_bits;
		logic [IN_W-1:0]  sublink_bits;
		logic             sublink_valid;
		logic             odd_parity;
		logic             self_inverse;
		logic             symmetric;
		logic             palindrome;
	} result_t;

endpackage

// File: sv/cba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_front
// Accepts strings, masks them to the configured length and registers the
// string with its length for the back end.
// ----------------------------------------------------------------------------
module cba_front #(
	parameter int MAX_BITS = cba_pkg::MAX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cba_pkg::IN_W-1:0]      loop_bits,
	input  logic [cba_pkg::LEN_W-1:0]     len_cfg,
	output logic                          s1_valid,
	input  logic                          s1_ready,
	output logic [MAX_BITS-1:0]           x_s1,
	output logic [cba_pkg::LEN_W-1:0]     n_s1
);

	localparam int WB = (MAX_BITS > cba_pkg::IN_W) ? MAX_BITS : cba_pkg::IN_W;

	logic [cba_pkg::LEN_W-1:0] n_eff;
	logic [MAX_BITS-1:0]       mask;
	logic [WB-1:0]             wide_in;

	always_comb begin
		if (len_cfg == '0)
			n_eff = cba_pkg::LEN_W'(1);
		else if (32'(len_cfg) > MAX_BITS)
			n_eff = cba_pkg::LEN_W'(MAX_BITS);
		else
			n_eff = len_cfg;
		for (int i = 0; i < MAX_BITS; i++)
			mask[i] = (i < int'(n_eff));
		wide_in = WB'(loop_bits);
	end

	assign in_ready = !s1_valid || s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (in_ready)
			s1_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1 <= wide_in[MAX_BITS-1:0] & mask;
			n_s1 <= n_eff;
		end
	end

endmodule

// File: sv/cba_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module cba_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	localparam int D = cba_pkg::QUEUE_DEPTH;

	logic [W-1:0] mem_q [D];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         wr_en, rd_en;

	assign wr_ready = cnt_q != 2'(D);
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= !wp_q;
			if (rd_en) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

endmodule

// File: sv/cba_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cba_back
// Computes all rotations of a string in parallel lanes, reduces them in a
// registered stage, and holds the result in an output register.
// ----------------------------------------------------------------------------
module cba_back #(
	parameter int MAX_BITS = cba_pkg::MAX_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  logic [MAX_BITS-1:0]       x_in,
	input  logic [cba_pkg::LEN_W-1:0] n_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cba_pkg::result_t          res_q
);

	localparam int WB = (MAX_BITS > cba_pkg::IN_W) ? MAX_BITS : cba_pkg::IN_W;
	localparam int NP = 1 << $clog2(MAX_BITS);

	// Stage 1: one lane per rotation amount.
	logic [MAX_BITS-1:0] rot      [MAX_BITS];
	logic [MAX_BITS-1:0] key      [MAX_BITS];
	logic [MAX_BITS-1:0] rot_s1   [MAX_BITS];
	logic [MAX_BITS-1:0] key_s1   [MAX_BITS];
	logic [MAX_BITS-1:0] lane_ok_s1;
	logic [MAX_BITS-1:0] per_hit, inv_hit, sym_hit, per_hit_s1;
	logic [MAX_BITS-1:0] mask, cmpl, rev, lnk, sub;
	logic                par;
	logic                v_s1, adv_s1, adv_out;
	logic                inv_s1, sym_s1, pal_s1, par_s1;
	logic [MAX_BITS-1:0] lnk_s1, sub_s1;
	logic [cba_pkg::LEN_W-1:0] n_s1;

	always_comb begin
		for (int i = 0; i < MAX_BITS; i++)
			mask[i] = (i < int'(n_in));
		cmpl = ~x_in & mask;
		rev  = '0;
		lnk  = '0;
		sub  = '0;
		par  = 1'b0;
		for (int i = 0; i < MAX_BITS; i++) begin
			if (i < int'(n_in)) begin
				rev[int'(n_in) - 1 - i] = x_in[i];
				lnk[i] = x_in[i] ^ x_in[(i + 1 < int'(n_in)) ? i + 1 : 0];
				par    = par ^ x_in[i];
			end
		end
		for (int i = 0; i + 1 < MAX_BITS; i++)
			sub[i+1] = (i + 1 < int'(n_in)) ? (sub[i] ^ x_in[i]) : 1'b0;
		for (int t = 0; t < MAX_BITS; t++) begin
			// With i below n and t at most n, one wrap brings i + t back in range.
			rot[t] = '0;
			for (int i = 0; i < MAX_BITS; i++)
				if (i < int'(n_in) && t <= int'(n_in))
					rot[t][(i + t >= int'(n_in)) ? i + t - int'(n_in) : i + t] = x_in[i];
			key[t] = '0;
			for (int i = 0; i < MAX_BITS; i++)
				if (i < int'(n_in))
					key[t][int'(n_in) - 1 - i] = rot[t][i];
			// The least shift that maps the string onto itself always divides n.
			per_hit[t] = (t >= 1) && (t <= int'(n_in)) && (rot[t] == x_in);
			inv_hit[t] = (t < int'(n_in)) && (rot[t] == cmpl);
			sym_hit[t] = (t < int'(n_in)) && (rot[t] == rev);
		end
	end

	assign adv_out = !out_valid || out_ready;
	assign adv_s1  = !v_s1 || adv_out;
	assign q_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= q_valid;
			if (adv_out) out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && adv_s1) begin
			for (int t = 0; t < MAX_BITS; t++) begin
				rot_s1[t]     <= rot[t];
				key_s1[t]     <= key[t];
				lane_ok_s1[t] <= t < int'(n_in);
			end
			per_hit_s1 <= per_hit;
			inv_s1 <= |inv_hit;
			sym_s1 <= |sym_hit;
			pal_s1 <= rev == x_in;
			par_s1 <= par;
			lnk_s1 <= lnk;
			sub_s1 <= par ? '0 : sub;
			n_s1   <= n_in;
		end
	end

	// Stage 2: minimum over the lanes; the earliest lane wins ties.
	// The lanes are paired off in a tree, and the left lane of a pair keeps
	// its place unless the right one is strictly smaller.
	logic [MAX_BITS-1:0]       best;
	logic [MAX_BITS-1:0]       tk [NP];
	logic [MAX_BITS-1:0]       tr [NP];
	logic [NP-1:0]             tok;
	logic [cba_pkg::LEN_W-1:0] per;
	logic [WB-1:0]             wr, wl, ws;

	always_comb begin
		for (int t = 0; t < NP; t++) begin
			if (t < MAX_BITS) begin
				tk[t]  = key_s1[t];
				tr[t]  = rot_s1[t];
				tok[t] = lane_ok_s1[t];
			end else begin
				tk[t]  = '1;
				tr[t]  = '0;
				tok[t] = 1'b0;
			end
		end
		for (int s = 1; s < NP; s = s * 2)
			for (int i = 0; i + s < NP; i = i + 2 * s)
				if (tok[i+s] && (!tok[i] || tk[i+s] < tk[i])) begin
					tk[i]  = tk[i+s];
					tr[i]  = tr[i+s];
					tok[i] = 1'b1;
				end
		best = tr[0];
		per = n_s1;
		for (int t = MAX_BITS - 1; t >= 1; t--)
			if (per_hit_s1[t]) per = cba_pkg::LEN_W'(t);
		wr = WB'(best);
		wl = WB'(lnk_s1);
		ws = WB'(sub_s1);
	end

	always_ff @(posedge clk) begin
		if (v_s1 && adv_out) begin
			res_q.min_rotation  <= wr[cba_pkg::IN_W-1:0];
			res_q.period        <= per;
			res_q.link_bits     <= wl[cba_pkg::IN_W-1:0];
			res_q.sublink_bits  <= ws[cba_pkg::IN_W-1:0];
			res_q.sublink_valid <= !par_s1;
			res_q.odd_parity    <= par_s1;
			res_q.self_inverse  <= inv_s1;
			res_q.symmetric     <= sym_s1;
			res_q.palindrome    <= pal_s1;
		end
	end

endmodule

// File: sv/circular_bitstring_analyzer_top.sv
`timescale 1ns / 1ps
// A string's path: front register, queue entry, lane stage, then the
// reduction/output register. Throughput: one string per cycle unless out_ready
// stalls the output; every stage is a single registered step.
// Reset: arst_n clears all valid flags and sets the stored length (len_q) to 16.
// ----------------------------------------------------------------------------
// circular_bitstring_analyzer_top
// Least rotation, period, link, sublink and symmetry tests of a bit loop.
// ----------------------------------------------------------------------------
module circular_bitstring_analyzer_top #(
	parameter int MAX_BITS = cba_pkg::MAX_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cba_pkg::LEN_W-1:0] loop_length,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [cba_pkg::IN_W-1:0]  loop_bits,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [cba_pkg::IN_W-1:0]  min_rotation,
	output logic [cba_pkg::LEN_W-1:0] period,
	output logic [cba_pkg::IN_W-1:0]  link_bits,
	output logic [cba_pkg::IN_W-1:0]  sublink_bits,
	output logic                      sublink_valid,
	output logic                      odd_parity,
	output logic                      self_inverse,
	output logic                      symmetric,
	output logic                      palindrome
);

	localparam int QW = MAX_BITS + cba_pkg::LEN_W;

	logic [cba_pkg::LEN_W-1:0] len_q;
	logic                      s1_valid, s1_ready, q_valid, q_ready;
	logic [MAX_BITS-1:0]       x_s1;
	logic [cba_pkg::LEN_W-1:0] n_s1;
	logic [QW-1:0]             q_out;
	cba_pkg::result_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_q <= cba_pkg::LEN_RESET;
		else if (cfg_valid)
			len_q <= loop_length;
	end

	cba_front #(.MAX_BITS(MAX_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .loop_bits,
		.len_cfg(len_q), .s1_valid, .s1_ready, .x_s1, .n_s1
	);

	cba_queue #(.W(QW)) u_queue (
		.clk, .arst_n,
		.wr_valid(s1_valid), .wr_ready(s1_ready), .wr_data({x_s1, n_s1}),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
	);

	cba_back #(.MAX_BITS(MAX_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready,
		.x_in(q_out[QW-1:cba_pkg::LEN_W]), .n_in(q_out[cba_pkg::LEN_W-1:0]),
		.out_valid, .out_ready, .res_q(res)
	);

	assign min_rotation  = res.min_rotation;
	assign period        = res.period;
	assign link_bits     = res.link_bits;
	assign sublink_bits  = res.sublink_bits;
	assign sublink_valid = res.sublink_valid;
	assign odd_parity    = res.odd_parity;
	assign self_inverse  = res.self_inverse;
	assign symmetric     = res.symmetric;
	assign palindrome    = res.palindrome;

endmodule

// File: verif/circular_bitstring_analyzer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_bitstring_analyzer_checker
// Watches the config, input and result channels of the analyzer, predicts
// each result from the accepted string and the current length, and compares.
// ----------------------------------------------------------------------------
module circular_bitstring_analyzer_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [cba_pkg::LEN_W-1:0] loop_length,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [cba_pkg::IN_W-1:0]  loop_bits,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  cba_pkg::result_t          got,
	input  logic                      drain_check,
	output int                        fail_count,
	output int                        pending,
	output int                        result_count
);

	logic [cba_pkg::LEN_W-1:0] cur_len;
	cba_pkg::result_t          analysis_q[$];

	function automatic logic [15:0] rotl(logic [15:0] x, int n, int t);
		logic [15:0] r;
		r = 0;
		for (int i = 0; i < n; i++)
			r[(i + t) % n] = x[i];
		return r;
	endfunction

	function automatic logic [15:0] mirror(logic [15:0] x, int n);
		logic [15:0] r;
		r = 0;
		for (int i = 0; i < n; i++)
			r[n - 1 - i] = x[i];
		return r;
	endfunction

	function automatic cba_pkg::result_t analyze(logic [15:0] raw,
			logic [cba_pkg::LEN_W-1:0] len);
		cba_pkg::result_t res;
		int               n;
		logic [15:0]      m, x, key, r, rev, cmp;
		logic             p, s;
		n = (len < 1) ? 1 : ((len > 16) ? 16 : int'(len));
		m = (n == 16) ? 16'hFFFF : ((16'h1 << n) - 16'h1);
		x = raw & m;
		res = '0;
		res.min_rotation = x;
		key = mirror(x, n);
		for (int t = 1; t < n; t++) begin
			r = rotl(x, n, t);
			if (mirror(r, n) < key) begin
				key = mirror(r, n);
				res.min_rotation = r;
			end
		end
		res.period = cba_pkg::LEN_W'(n);
		for (int d = n; d >= 1; d--)
			if (n % d == 0 && rotl(x, n, d % n) == x)
				res.period = cba_pkg::LEN_W'(d);
		p = 0;
		for (int i = 0; i < n; i++) begin
			res.link_bits[i] = x[i] ^ x[(i + 1) % n];
			p ^= x[i];
		end
		if (!p) begin
			s = 0;
			for (int i = 0; i + 1 < n; i++) begin
				s ^= x[i];
				res.sublink_bits[i + 1] = s;
			end
		end
		res.sublink_valid = !p;
		res.odd_parity = p;
		rev = mirror(x, n);
		cmp = ~x & m;
		for (int t = 0; t < n; t++) begin
			if (rotl(cmp, n, t) == x) res.self_inverse = 1;
			if (rotl(rev, n, t) == x) res.symmetric = 1;
		end
		res.palindrome = (rev == x);
		return res;
	endfunction

	assign pending = analysis_q.size();

	always @(posedge clk or negedge arst_n) begin : monitor
		int               bump;
		cba_pkg::result_t e;
		if (!arst_n) begin
			cur_len <= cba_pkg::LEN_RESET;
			fail_count <= 0;
			result_count <= 0;
			analysis_q.delete();
		end else begin
			bump = 0;
			if (cfg_valid && cfg_ready)
				cur_len <= loop_length;
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (analysis_q.size() == 0) begin
					if (fail_count + bump < 10)
						$display("Unexpected result transfer: %p", got);
					bump++;
				end else begin
					e = analysis_q.pop_front();
					if (e !== got) begin
						if (fail_count + bump < 10)
							$display("Mismatch: expected %p actual %p", e, got);
						bump++;
					end
				end
			end
			if (in_valid && in_ready)
				analysis_q = {analysis_q, analyze(loop_bits, cur_len)};
			if (drain_check && analysis_q.size() != 0) begin
				$display("%0d results never arrived", analysis_q.size());
				bump++;
				analysis_q.delete();
			end
			fail_count <= fail_count + bump;
		end
	end
endmodule

// File: verif/circular_bitstring_analyzer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_bitstring_analyzer_top_tb
// Drives strings at several loop lengths with random gaps on both sides and
// lets the checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
module circular_bitstring_analyzer_top_tb;

	logic                      clk = 0;
	logic                      arst_n = 0;
	logic                      cfg_valid = 0;
	logic                      cfg_ready;
	logic [cba_pkg::LEN_W-1:0] loop_length = 0;
	logic                      in_valid = 0;
	logic                      in_ready;
	logic [cba_pkg::IN_W-1:0]  loop_bits = 0;
	logic                      out_valid;
	logic                      out_ready = 0;
	cba_pkg::result_t          res;
	logic                      drain_check = 0;
	int                        fail_count, pending, result_count;
	int                        sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	circular_bitstring_analyzer_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .loop_length(loop_length),
		.in_valid(in_valid), .in_ready(in_ready), .loop_bits(loop_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.min_rotation(res.min_rotation), .period(res.period),
		.link_bits(res.link_bits), .sublink_bits(res.sublink_bits),
		.sublink_valid(res.sublink_valid), .odd_parity(res.odd_parity),
		.self_inverse(res.self_inverse), .symmetric(res.symmetric),
		.palindrome(res.palindrome)
	);

	circular_bitstring_analyzer_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .loop_length(loop_length),
		.in_valid(in_valid), .in_ready(in_ready), .loop_bits(loop_bits),
		.out_valid(out_valid), .out_ready(out_ready), .got(res),
		.drain_check(drain_check), .fail_count(fail_count),
		.pending(pending), .result_count(result_count)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver stalls at random; some phases run with ready held high.
	bit sink_free = 0;
	always @(negedge clk) begin
		if (sink_free)
			out_ready <= 1;
		else
			out_ready <= ($urandom_range(0, 99) < 70) || (gap_len() == 0);
	end

	// Valid stays high after a transfer; this task drops it only when a gap follows.
	task automatic send_string(logic [cba_pkg::IN_W-1:0] v, bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1;
		loop_bits <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Waits for the pipe to drain, then writes a new length.
	task automatic set_length(logic [cba_pkg::LEN_W-1:0] len);
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		drain_check <= 1;
		@(negedge clk);
		drain_check <= 0;
		cfg_valid <= 1;
		loop_length <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Sends a burst; back to back transfers keep valid high between items.
	task automatic send_burst(int count, bit shaped);
		logic [cba_pkg::IN_W-1:0] v;
		bit                       tight;
		for (int i = 0; i < count; i++) begin
			v = $urandom();
			if (shaped) begin
				case ($urandom_range(0, 5))
					0: v = {2{v[7:0]}};
					1: v = {4{v[3:0]}};
					2: v = {8{v[1:0]}};
					default: ;
				endcase
			end
			tight = ($urandom_range(0, 3) == 0);
			send_string(v, tight);
		end
	endtask

	logic [cba_pkg::LEN_W-1:0] lens[$] = '{16, 1, 0, 31, 2, 7, 8, 15, 3, 12, 5, 16};

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// Directed strings at the reset length.
		send_string(16'h0000, 0); send_string(16'hFFFF, 0);
		send_string(16'h5555, 0); send_string(16'hAAAA, 0);
		send_string(16'h0001, 0); send_string(16'h8000, 0);
		send_string(16'h00FF, 0); send_string(16'h0F0F, 0);
		send_string(16'h8001, 0); send_string(16'h0003, 0);
		send_string(16'h1248, 0); send_string(16'h7FFE, 0);
		set_length(3);
		send_string(16'hFFF8, 0); send_string(16'h0005, 0);
		send_string(16'h0007, 0); send_string(16'h0001, 0);
		foreach (lens[k]) begin
			set_length(lens[k]);
			sink_free = (k % 4 == 3);
			send_burst(100, 1);
		end
		in_valid <= 0;
		sink_free = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		drain_check <= 1;
		@(negedge clk);
		drain_check <= 0;
		@(negedge clk);
		$display("Sent %0d strings over %0d loop lengths, %0d results checked.",
			sent, lens.size() + 2, result_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results outstanding", pending);
		$display("TEST FAILED");
		$finish;
	end
endmodule

// File: filelist.f
sv/cba_pkg.sv
sv/cba_front.sv
sv/cba_queue.sv
sv/cba_back.sv
sv/circular_bitstring_analyzer_top.sv
verif/circular_bitstring_analyzer_checker.sv
verif/circular_bitstring_analyzer_top_tb.sv
